@@ rtl/core/i2c_register_access_master_defines.svh @@
// Assertion macros shared by the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define I2CRAM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("i2cram implication check failed");

// Check that a condition never holds.
`define I2CRAM_ASSERT_NEVER(label, clk, rst_n, a) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(a)) \
    else $error("i2cram forbidden condition seen");

`endif

@@ rtl/core/i2cram_pkg.sv @@
// Shared types and constants of the I2C register access master.
package i2cram_pkg;

  localparam logic [7:0] ACK_WAIT_RESET = 8'd250;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_BURST = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] device_byte;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] burst_length;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] rx_byte;
    logic       read_last;
    logic       done_res;
  } result_t;

endpackage

@@ rtl/core/i2c_register_access_master.sv @@
// Top level of the I2C register access master.
// Each input transfer is one bus tick carrying the sampled SDA level and, when the
// master is idle, an optional command (register write, register read, burst read).
// Every tick yields exactly one result transfer with the SCL and SDA levels to drive,
// busy and done flags, and any received byte. The master sustains one tick per clock
// cycle while the consumer keeps out_ready_i high: the sequencer advances one ticking bus
// phase per tick in a single combinational pass between the input register and the result
// register. Commands seen while busy are dropped. The user must write ack_wait_limit
// through cfg_we_i/cfg_data_i only while idle; the block does not enforce this.
`include "i2c_register_access_master_defines.svh"

module i2c_register_access_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] device_byte_i,
  input  logic [7:0] register_address_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] burst_length_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       read_valid_o,
  output logic [7:0] rx_byte_o,
  output logic       read_last_o,
  output logic       done_res_o
);

  i2cram_pkg::item_t   in_item, held_item;
  i2cram_pkg::result_t step_res, out_res;
  logic                held_valid;
  logic                out_free;
  logic                advance;

  assign in_item.opcode           = opcode_i;
  assign in_item.device_byte      = device_byte_i;
  assign in_item.register_address = register_address_i;
  assign in_item.write_data       = write_data_i;
  assign in_item.burst_length     = burst_length_i;
  assign in_item.sda_in           = sda_in_i;

  // Step the sequencer when a tick is held and the result slot can take it.
  assign advance = held_valid && out_free;

  i2cram_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  i2cram_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .item_i     (held_item),
    .result_o   (step_res)
  );

  i2cram_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign scl_out_o    = out_res.scl_out;
  assign sda_out_o    = out_res.sda_out;
  assign busy_res_o   = out_res.busy_res;
  assign read_valid_o = out_res.read_valid;
  assign rx_byte_o    = out_res.rx_byte;
  assign read_last_o  = out_res.read_last;
  assign done_res_o   = out_res.done_res;

  `I2CRAM_ASSERT_IMPLY(a_stall_only_on_full, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  `I2CRAM_ASSERT_IMPLY(a_read_in_busy, clk_i, rst_ni, out_valid_o && read_valid_o, busy_res_o)
  `I2CRAM_ASSERT_IMPLY(a_last_is_read, clk_i, rst_ni, out_valid_o && read_last_o, read_valid_o)
  `I2CRAM_ASSERT_IMPLY(a_stop_lines_high, clk_i, rst_ni, out_valid_o && done_res_o, scl_out_o && sda_out_o)
  `I2CRAM_ASSERT_NEVER(a_read_not_done, clk_i, rst_ni, out_valid_o && read_valid_o && done_res_o)

endmodule

@@ rtl/core/i2cram_in_reg.sv @@
// Input register: holds one accepted tick item until the sequencer takes it.
module i2cram_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2cram_pkg::item_t item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output i2cram_pkg::item_t item_o
);

  logic              valid_d, valid_q;
  logic              take;
  i2cram_pkg::item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/i2cram_seq.sv @@
// Bus sequencer: one phase step per tick, plus the acknowledge wait limit register.
module i2cram_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                advance_i,
  input  i2cram_pkg::item_t   item_i,
  output i2cram_pkg::result_t result_o
);

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_S1   = 5'd1;
  localparam logic [4:0] PH_S2   = 5'd2;
  localparam logic [4:0] PH_S3   = 5'd3;
  localparam logic [4:0] PH_S4   = 5'd4;
  localparam logic [4:0] PH_WA   = 5'd5;
  localparam logic [4:0] PH_WB   = 5'd6;
  localparam logic [4:0] PH_WC   = 5'd7;
  localparam logic [4:0] PH_KA   = 5'd8;
  localparam logic [4:0] PH_KW   = 5'd9;
  localparam logic [4:0] PH_RA   = 5'd10;
  localparam logic [4:0] PH_RB   = 5'd11;
  localparam logic [4:0] PH_RC   = 5'd12;
  localparam logic [4:0] PH_AA   = 5'd13;
  localparam logic [4:0] PH_AB   = 5'd14;
  localparam logic [4:0] PH_T1   = 5'd15;
  localparam logic [4:0] PH_T2   = 5'd16;
  localparam logic [4:0] PH_T3   = 5'd17;
  localparam logic [4:0] PH_T4   = 5'd18;

  // Byte sequence positions.
  localparam logic [2:0] SEG_DEV_WR = 3'd0;
  localparam logic [2:0] SEG_REG    = 3'd1;
  localparam logic [2:0] SEG_DATA   = 3'd2;
  localparam logic [2:0] SEG_DEV_RD = 3'd3;
  localparam logic [2:0] SEG_READ   = 3'd4;

  logic [7:0] limit_q;
  logic [4:0] phase_d, phase_q;
  logic [2:0] bit_d, bit_q;
  logic [7:0] shift_d, shift_q;
  logic [7:0] left_d, left_q;
  logic [7:0] wait_d, wait_q;
  logic [7:0] dev_d, dev_q;
  logic [7:0] reg_d, reg_q;
  logic [7:0] data_d, data_q;
  logic [1:0] kind_d, kind_q;
  logic [2:0] seg_d, seg_q;
  logic       scl_d, scl_q;
  logic       sda_d, sda_q;

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    wait_d  = wait_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    data_d  = data_q;
    kind_d  = kind_q;
    seg_d   = seg_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    result_o = '0;

    // Resolve the phases that pass on without using up the tick.
    unique case (phase_d)
      PH_IDLE: begin
        if (item_i.opcode != i2cram_pkg::OP_TICK) begin
          kind_d  = item_i.opcode;
          dev_d   = item_i.device_byte;
          reg_d   = item_i.register_address;
          data_d  = item_i.write_data;
          left_d  = (item_i.opcode == i2cram_pkg::OP_READ) ? 8'd1 : item_i.burst_length;
          seg_d   = SEG_DEV_WR;
          phase_d = PH_S1;
        end
      end
      PH_S4: begin
        scl_d   = 1'b0;
        shift_d = (seg_d == SEG_DEV_WR) ? dev_d : dev_d + 8'd1;
        bit_d   = 3'd0;
        phase_d = PH_WA;
      end
      PH_KW: begin
        if (!(item_i.sda_in && (wait_d < limit_q))) begin
          scl_d = 1'b0;
          case (seg_d)
            SEG_DEV_WR: begin
              seg_d   = SEG_REG;
              shift_d = reg_d;
              bit_d   = 3'd0;
              phase_d = PH_WA;
            end
            SEG_REG: begin
              if (kind_d == i2cram_pkg::OP_WRITE) begin
                seg_d   = SEG_DATA;
                shift_d = data_d;
                bit_d   = 3'd0;
                phase_d = PH_WA;
              end else begin
                seg_d   = SEG_DEV_RD;
                phase_d = PH_S1;
              end
            end
            SEG_DEV_RD: begin
              seg_d = SEG_READ;
              if (left_d == 8'd0) begin
                phase_d = PH_T1;
              end else begin
                shift_d = 8'd0;
                bit_d   = 3'd0;
                phase_d = PH_RA;
              end
            end
            default: phase_d = PH_T1;
          endcase
        end
      end
      default: ;
    endcase

    result_o.busy_res = (phase_d != PH_IDLE);

    // Ticking action of the phase now in effect.
    unique case (phase_d)
      PH_IDLE: ;
      PH_S1: begin sda_d = 1'b1; phase_d = PH_S2; end
      PH_S2: begin scl_d = 1'b1; phase_d = PH_S3; end
      PH_S3: begin sda_d = 1'b0; phase_d = PH_S4; end
      PH_WA: begin sda_d = shift_d[7]; phase_d = PH_WB; end
      PH_WB: begin scl_d = 1'b1; phase_d = PH_WC; end
      PH_WC: begin
        scl_d   = 1'b0;
        shift_d = {shift_d[6:0], 1'b0};
        if (bit_d == 3'd7) begin
          phase_d = PH_KA;
        end else begin
          bit_d   = bit_d + 3'd1;
          phase_d = PH_WA;
        end
      end
      PH_KA: begin
        sda_d   = 1'b1;
        scl_d   = 1'b1;
        wait_d  = 8'd0;
        phase_d = PH_KW;
      end
      PH_KW: wait_d = wait_d + 8'd1;
      PH_RA: begin
        sda_d   = 1'b1;
        shift_d = 8'd0;
        bit_d   = 3'd0;
        phase_d = PH_RB;
      end
      PH_RB: begin
        scl_d   = 1'b1;
        shift_d = {shift_d[6:0], item_i.sda_in};
        phase_d = PH_RC;
      end
      PH_RC: begin
        scl_d = 1'b0;
        if (bit_d == 3'd7) begin
          result_o.read_valid = 1'b1;
          result_o.rx_byte    = shift_d;
          result_o.read_last  = (left_d == 8'd1);
          phase_d = PH_AA;
        end else begin
          bit_d   = bit_d + 3'd1;
          phase_d = PH_RB;
        end
      end
      PH_AA: begin
        // NACK the last byte, ACK the others.
        sda_d   = (left_d == 8'd1);
        scl_d   = 1'b1;
        phase_d = PH_AB;
      end
      PH_AB: begin
        scl_d   = 1'b0;
        left_d  = left_d - 8'd1;
        phase_d = (left_d != 8'd0) ? PH_RA : PH_T1;
      end
      PH_T1: begin sda_d = 1'b0; phase_d = PH_T2; end
      PH_T2: begin scl_d = 1'b0; phase_d = PH_T3; end
      PH_T3: begin scl_d = 1'b1; phase_d = PH_T4; end
      PH_T4: begin
        sda_d = 1'b1;
        result_o.done_res = 1'b1;
        phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase

    result_o.scl_out = scl_d;
    result_o.sda_out = sda_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= i2cram_pkg::ACK_WAIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      left_q  <= 8'd0;
      wait_q  <= 8'd0;
      dev_q   <= 8'd0;
      reg_q   <= 8'd0;
      data_q  <= 8'd0;
      kind_q  <= 2'd0;
      seg_q   <= SEG_DEV_WR;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (advance_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      wait_q  <= wait_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      data_q  <= data_d;
      kind_q  <= kind_d;
      seg_q   <= seg_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

@@ rtl/core/i2cram_out_reg.sv @@
// Result register: holds one tick result until the consumer takes it.
module i2cram_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  i2cram_pkg::result_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cram_pkg::result_t result_o
);

  logic                valid_d, valid_q;
  i2cram_pkg::result_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = advance_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ bench/i2cram_tick_checker.sv @@
// Tick predictor and result checker for the I2C register access master.
`timescale 1ns / 100ps

module i2cram_tick_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] device_byte_i,
  input  logic [7:0] register_address_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] burst_length_i,
  input  logic       sda_in_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       scl_out_i,
  input  logic       sda_out_i,
  input  logic       busy_res_i,
  input  logic       read_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       read_last_i,
  input  logic       done_res_i,
  output int         pending_o,
  output logic       seq_idle_o,
  output int         fail_count_o
);

  typedef enum logic [4:0] {
    SEQ_IDLE,
    START_RELEASE,
    START_SCL_HIGH,
    START_SDA_LOW,
    START_SCL_LOW,
    TX_DATA,
    TX_SCL_HIGH,
    TX_SCL_LOW,
    ACK_CLOCK,
    ACK_WAIT,
    RX_RELEASE,
    RX_SAMPLE,
    RX_SCL_LOW,
    RX_ACK_DRIVE,
    RX_ACK_LOW,
    STOP_SDA_LOW,
    STOP_SCL_LOW,
    STOP_SCL_HIGH,
    STOP_RELEASE
  } bus_phase_e;

  typedef enum logic [2:0] {
    SEG_DEVICE,
    SEG_REGISTER,
    SEG_DATA,
    SEG_READ_ADDR,
    SEG_READ
  } segment_e;

  logic [7:0] ack_limit;
  bus_phase_e phase;
  segment_e   segment;
  logic [2:0] bit_idx;
  logic [7:0] shift_reg;
  logic [7:0] bytes_left;
  logic [7:0] wait_ticks;
  logic [7:0] cmd_device;
  logic [7:0] cmd_register;
  logic [7:0] cmd_data;
  logic [1:0] cmd_kind;
  logic       scl_level;
  logic       sda_level;

  i2cram_pkg::result_t predicted_ticks[$];
  i2cram_pkg::result_t got;
  i2cram_pkg::result_t want;
  i2cram_pkg::item_t   tick_in;
  int                  mismatches = 0;

  function automatic void load_byte(input logic [7:0] b);
    shift_reg = b;
    bit_idx   = 3'd0;
    phase     = TX_DATA;
  endfunction

  // Advance the sequencer by one bus tick and return the line levels it drives.
  function automatic i2cram_pkg::result_t bus_tick(input i2cram_pkg::item_t it);
    i2cram_pkg::result_t r;
    logic                ticked;
    int                  guard;
    r      = '0;
    ticked = 1'b0;
    for (guard = 0; guard < 8 && !ticked; guard++) begin
      if (phase != SEQ_IDLE) r.busy_res = 1'b1;
      case (phase)
        SEQ_IDLE: begin
          if (it.opcode != i2cram_pkg::OP_TICK) begin
            cmd_kind     = it.opcode;
            cmd_device   = it.device_byte;
            cmd_register = it.register_address;
            cmd_data     = it.write_data;
            bytes_left   = (it.opcode == i2cram_pkg::OP_READ) ? 8'd1 : it.burst_length;
            segment      = SEG_DEVICE;
            phase        = START_RELEASE;
          end else begin
            ticked = 1'b1;
          end
        end
        START_RELEASE: begin
          sda_level = 1'b1; phase = START_SCL_HIGH; ticked = 1'b1;
        end
        START_SCL_HIGH: begin
          scl_level = 1'b1; phase = START_SDA_LOW; ticked = 1'b1;
        end
        START_SDA_LOW: begin
          sda_level = 1'b0; phase = START_SCL_LOW; ticked = 1'b1;
        end
        START_SCL_LOW: begin
          scl_level = 1'b0;
          load_byte(segment == SEG_DEVICE ? cmd_device : cmd_device + 8'd1);
        end
        TX_DATA: begin
          sda_level = shift_reg[7]; phase = TX_SCL_HIGH; ticked = 1'b1;
        end
        TX_SCL_HIGH: begin
          scl_level = 1'b1; phase = TX_SCL_LOW; ticked = 1'b1;
        end
        TX_SCL_LOW: begin
          scl_level = 1'b0;
          shift_reg = {shift_reg[6:0], 1'b0};
          if (bit_idx == 3'd7) begin
            phase = ACK_CLOCK;
          end else begin
            bit_idx++;
            phase = TX_DATA;
          end
          ticked = 1'b1;
        end
        ACK_CLOCK: begin
          sda_level  = 1'b1;
          scl_level  = 1'b1;
          wait_ticks = 8'd0;
          phase      = ACK_WAIT;
          ticked     = 1'b1;
        end
        ACK_WAIT: begin
          // Hold SCL high until the slave pulls SDA low or the limit runs out.
          if (it.sda_in && wait_ticks < ack_limit) begin
            wait_ticks++;
            ticked = 1'b1;
          end else begin
            scl_level = 1'b0;
            case (segment)
              SEG_DEVICE: begin
                segment = SEG_REGISTER;
                load_byte(cmd_register);
              end
              SEG_REGISTER: begin
                if (cmd_kind == i2cram_pkg::OP_WRITE) begin
                  segment = SEG_DATA;
                  load_byte(cmd_data);
                end else begin
                  segment = SEG_READ_ADDR;
                  phase   = START_RELEASE;
                end
              end
              SEG_READ_ADDR: begin
                segment = SEG_READ;
                if (bytes_left == 8'd0) begin
                  phase = STOP_SDA_LOW;
                end else begin
                  shift_reg = 8'd0;
                  bit_idx   = 3'd0;
                  phase     = RX_RELEASE;
                end
              end
              default: phase = STOP_SDA_LOW;
            endcase
          end
        end
        RX_RELEASE: begin
          sda_level = 1'b1;
          shift_reg = 8'd0;
          bit_idx   = 3'd0;
          phase     = RX_SAMPLE;
          ticked    = 1'b1;
        end
        RX_SAMPLE: begin
          scl_level = 1'b1;
          shift_reg = {shift_reg[6:0], it.sda_in};
          phase     = RX_SCL_LOW;
          ticked    = 1'b1;
        end
        RX_SCL_LOW: begin
          scl_level = 1'b0;
          if (bit_idx == 3'd7) begin
            r.read_valid = 1'b1;
            r.rx_byte    = shift_reg;
            r.read_last  = (bytes_left == 8'd1);
            phase        = RX_ACK_DRIVE;
          end else begin
            bit_idx++;
            phase = RX_SAMPLE;
          end
          ticked = 1'b1;
        end
        RX_ACK_DRIVE: begin
          // ACK every byte but the last, which gets a NACK.
          sda_level = (bytes_left == 8'd1);
          scl_level = 1'b1;
          phase     = RX_ACK_LOW;
          ticked    = 1'b1;
        end
        RX_ACK_LOW: begin
          scl_level  = 1'b0;
          bytes_left = bytes_left - 8'd1;
          phase      = (bytes_left != 8'd0) ? RX_RELEASE : STOP_SDA_LOW;
          ticked     = 1'b1;
        end
        STOP_SDA_LOW: begin
          sda_level = 1'b0; phase = STOP_SCL_LOW; ticked = 1'b1;
        end
        STOP_SCL_LOW: begin
          scl_level = 1'b0; phase = STOP_SCL_HIGH; ticked = 1'b1;
        end
        STOP_SCL_HIGH: begin
          scl_level = 1'b1; phase = STOP_RELEASE; ticked = 1'b1;
        end
        STOP_RELEASE: begin
          sda_level  = 1'b1;
          r.done_res = 1'b1;
          phase      = SEQ_IDLE;
          ticked     = 1'b1;
        end
        default: begin
          phase  = SEQ_IDLE;
          ticked = 1'b1;
        end
      endcase
    end
    r.scl_out = scl_level;
    r.sda_out = sda_level;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_limit    = i2cram_pkg::ACK_WAIT_RESET;
      phase        = SEQ_IDLE;
      segment      = SEG_DEVICE;
      bit_idx      = 3'd0;
      shift_reg    = 8'd0;
      bytes_left   = 8'd0;
      wait_ticks   = 8'd0;
      cmd_device   = 8'd0;
      cmd_register = 8'd0;
      cmd_data     = 8'd0;
      cmd_kind     = 2'd0;
      scl_level    = 1'b1;
      sda_level    = 1'b1;
      predicted_ticks.delete();
    end else begin
      if (cfg_we_i) ack_limit = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        got = {scl_out_i, sda_out_i, busy_res_i, read_valid_i, rx_byte_i,
               read_last_i, done_res_i};
        if (predicted_ticks.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %p", $time, got);
          mismatches++;
        end else begin
          want = predicted_ticks.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("read_last", 8'(want.read_last), 8'(got.read_last));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        end
      end
      if (in_valid_i && in_ready_i) begin
        tick_in = {opcode_i, device_byte_i, register_address_i, write_data_i,
                   burst_length_i, sda_in_i};
        predicted_ticks.push_back(bus_tick(tick_in));
      end
    end
    pending_o    <= predicted_ticks.size();
    seq_idle_o   <= (phase == SEQ_IDLE);
    fail_count_o <= mismatches;
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives bus ticks and register commands into the I2C master and gives the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int ROUND_TICKS  = 120;

  typedef enum logic [1:0] {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_mode_e;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       cfg_we           = 1'b0;
  logic [7:0] cfg_data         = 8'd0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic [1:0] opcode           = i2cram_pkg::OP_TICK;
  logic [7:0] device_byte      = 8'd0;
  logic [7:0] register_address = 8'd0;
  logic [7:0] write_data       = 8'd0;
  logic [7:0] burst_length     = 8'd0;
  logic       sda_in           = 1'b1;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] rx_byte;
  logic       read_last;
  logic       done_res;

  int   pending;
  logic seq_idle;
  int   fail_count;

  int send_gap   = 13;
  int recv_stall = 66;
  int sent_ticks = 0;
  int cycles     = 0;

  always #1 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  i2c_register_access_master dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .opcode_i           (opcode),
    .device_byte_i      (device_byte),
    .register_address_i (register_address),
    .write_data_i       (write_data),
    .burst_length_i     (burst_length),
    .sda_in_i           (sda_in),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .scl_out_o          (scl_out),
    .sda_out_o          (sda_out),
    .busy_res_o         (busy_res),
    .read_valid_o       (read_valid),
    .rx_byte_o          (rx_byte),
    .read_last_o        (read_last),
    .done_res_o         (done_res)
  );

  i2cram_tick_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .opcode_i           (opcode),
    .device_byte_i      (device_byte),
    .register_address_i (register_address),
    .write_data_i       (write_data),
    .burst_length_i     (burst_length),
    .sda_in_i           (sda_in),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .scl_out_i          (scl_out),
    .sda_out_i          (sda_out),
    .busy_res_i         (busy_res),
    .read_valid_i       (read_valid),
    .rx_byte_i          (rx_byte),
    .read_last_i        (read_last),
    .done_res_i         (done_res),
    .pending_o          (pending),
    .seq_idle_o         (seq_idle),
    .fail_count_o       (fail_count)
  );

  // Plain tick with random filler in the command fields.
  function automatic i2cram_pkg::item_t filler_tick(input sda_mode_e mode);
    i2cram_pkg::item_t it;
    it.opcode           = i2cram_pkg::OP_TICK;
    it.device_byte      = 8'($urandom);
    it.register_address = 8'($urandom);
    it.write_data       = 8'($urandom);
    it.burst_length     = 8'($urandom);
    case (mode)
      SDA_HIGH: it.sda_in = 1'b1;
      SDA_LOW:  it.sda_in = 1'b0;
      default:  it.sda_in = 1'($urandom);
    endcase
    return it;
  endfunction

  task automatic send_item(input i2cram_pkg::item_t it);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    opcode           <= it.opcode;
    device_byte      <= it.device_byte;
    register_address <= it.register_address;
    write_data       <= it.write_data;
    burst_length     <= it.burst_length;
    sda_in           <= it.sda_in;
    do @(posedge clk); while (!in_ready);
    sent_ticks++;
  endtask

  // Issue one command, then tick until the sequencer is back to idle.
  task automatic run_command(input logic [1:0] op, input logic [7:0] dev,
                             input logic [7:0] reg_addr, input logic [7:0] data,
                             input logic [7:0] len, input sda_mode_e mode, input bit noisy);
    i2cram_pkg::item_t it;
    it                  = filler_tick(mode);
    it.opcode           = op;
    it.device_byte      = dev;
    it.register_address = reg_addr;
    it.write_data       = data;
    it.burst_length     = len;
    send_item(it);
    do begin
      it = filler_tick(mode);
      if (noisy) it.opcode = 2'($urandom_range(3, 1));
      else if ($urandom_range(99) < 5) it.opcode = 2'($urandom);
      send_item(it);
    end while (!seq_idle);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input logic [7:0] value);
    // Finish any transaction a stray command started, then drain.
    do send_item(filler_tick(SDA_RANDOM)); while (!seq_idle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !seq_idle);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_round(input int gap_pct, input int stall_pct, input logic [7:0] limit);
    int        first_tick;
    int        pick;
    logic [7:0] len;
    sda_mode_e mode;
    send_gap   = gap_pct;
    recv_stall = stall_pct;
    write_limit(limit);
    first_tick = sent_ticks;
    while (sent_ticks - first_tick < ROUND_TICKS) begin
      if ($urandom_range(99) < 3) hold_until_drained();
      len  = ($urandom_range(99) < 80) ? 8'($urandom_range(4, 0)) : 8'($urandom_range(24, 5));
      pick = $urandom_range(99);
      mode = (pick < 70) ? SDA_RANDOM : (pick < 85) ? SDA_HIGH : SDA_LOW;
      run_command(2'($urandom_range(3, 1)), 8'($urandom), 8'($urandom), 8'($urandom), len,
                  mode, $urandom_range(99) < 5);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands at the reset acknowledge limit.
    run_command(i2cram_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0);
    run_command(i2cram_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SDA_RANDOM, 1'b0);
    // Read address wraps from ff to 00.
    run_command(i2cram_pkg::OP_READ, 8'hFF, 8'hA5, 8'h5A, 8'h00, SDA_RANDOM, 1'b0);
    run_command(i2cram_pkg::OP_READ, 8'h3C, 8'h00, 8'h00, 8'hFF, SDA_LOW, 1'b0);
    run_command(i2cram_pkg::OP_BURST, 8'hA0, 8'h10, 8'h00, 8'h00, SDA_RANDOM, 1'b0);
    run_command(i2cram_pkg::OP_BURST, 8'hA0, 8'h11, 8'h00, 8'h01, SDA_RANDOM, 1'b0);
    // Commands during the transfer must be dropped.
    run_command(i2cram_pkg::OP_BURST, 8'h7E, 8'h20, 8'h00, 8'h03, SDA_LOW, 1'b1);
    run_command(i2cram_pkg::OP_BURST, 8'h81, 8'h7F, 8'h00, 8'h05, SDA_RANDOM, 1'b0);
    // No slave ACK: every acknowledge wait runs to its limit.
    write_limit(8'h28);
    run_command(i2cram_pkg::OP_WRITE, 8'h42, 8'h01, 8'h99, 8'h00, SDA_HIGH, 1'b0);
    write_limit(8'h00);
    run_command(i2cram_pkg::OP_WRITE, 8'h42, 8'h02, 8'h33, 8'h00, SDA_HIGH, 1'b0);
    run_command(i2cram_pkg::OP_BURST, 8'h42, 8'h03, 8'h00, 8'h02, SDA_HIGH, 1'b0);
    write_limit(8'h01);
    run_command(i2cram_pkg::OP_READ, 8'h10, 8'h04, 8'h00, 8'h00, SDA_HIGH, 1'b0);

    random_round(13, 66, 8'($urandom_range(8, 2)));
    random_round(66, 13, 8'h30);
    random_round(0, 0, 8'h00);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
